// ===== rtl/tpoc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpoc_pkg
// Shared types, codes and Q16.16 constants of the three-position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tpoc_pkg;

    typedef enum logic [2:0] {
        MODE_OS   = 3'd0,
        MODE_MAN  = 3'd1,
        MODE_AUT  = 3'd2,
        MODE_CAS  = 3'd3,
        MODE_RCAS = 3'd4,
        MODE_ROUT = 3'd5
    } mode_t;

    localparam logic [2:0] REQ_KEEP = 3'd0;
    localparam logic [2:0] REQ_ROUT = 3'd6;

    localparam logic [1:0] PSW_NONE   = 2'd0;
    localparam logic [1:0] PSW_LOW    = 2'd1;
    localparam logic [1:0] PSW_HIGH   = 2'd2;
    localparam logic [1:0] PSW_PRESET = 2'd3;

    localparam logic [2:0] CFG_CONTROL_FLAGS      = 3'd0;
    localparam logic [2:0] CFG_DEADBAND           = 3'd1;
    localparam logic [2:0] CFG_HYSTERESIS_BAND    = 3'd2;
    localparam logic [2:0] CFG_SV_HIGH_LIMIT      = 3'd3;
    localparam logic [2:0] CFG_SV_LOW_LIMIT       = 3'd4;
    localparam logic [2:0] CFG_PRESET_OUTPUT      = 3'd5;
    localparam logic [2:0] CFG_OUTPUT_LOW_PRESET  = 3'd6;
    localparam logic [2:0] CFG_OUTPUT_HIGH_PRESET = 3'd7;

    localparam logic signed [31:0] Q_ZERO    = 32'sd0;
    localparam logic signed [31:0] Q_HALF    = 32'sd3276800;
    localparam logic signed [31:0] Q_FULL    = 32'sd6553600;
    localparam logic signed [31:0] Q_LOW_PIN = 32'sd1605632;
    localparam logic signed [31:0] Q_HI_PIN  = 32'sd4908646;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               direct_action;
        logic               sp_track;
        logic [30:0]        deadband;
        logic [30:0]        hysteresis_band;
        logic signed [31:0] sv_high_limit;
        logic signed [31:0] sv_low_limit;
        logic signed [31:0] preset_output;
        logic signed [31:0] output_low_preset;
        logic signed [31:0] output_high_preset;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] process_value;
        logic               cascade_connected;
        logic signed [31:0] cascade_setpoint;
        logic signed [31:0] remote_setpoint;
        logic signed [31:0] remote_output;
        logic [1:0]         preset_switch;
        logic [2:0]         mode_request;
        logic               manual_write;
        logic signed [31:0] manual_value;
    } item_t;

    typedef struct packed {
        logic               open_pin;
        logic               close_pin;
        logic signed [31:0] output_value;
        logic signed [31:0] setpoint_value;
        mode_t              current_mode;
        logic               bad_flag;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/tpoc_cfg.sv =====
// ----------------------------------------------------------------------------
// tpoc_cfg
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tpoc_cfg
    import tpoc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_CONTROL_FLAGS:
                begin
                    cfg_next.direct_action = cfg_data[0];
                    cfg_next.sp_track      = cfg_data[1];
                end
                CFG_DEADBAND:           cfg_next.deadband           = cfg_data[30:0];
                CFG_HYSTERESIS_BAND:    cfg_next.hysteresis_band    = cfg_data[30:0];
                CFG_SV_HIGH_LIMIT:      cfg_next.sv_high_limit      = cfg_data;
                CFG_SV_LOW_LIMIT:       cfg_next.sv_low_limit       = cfg_data;
                CFG_PRESET_OUTPUT:      cfg_next.preset_output      = cfg_data;
                CFG_OUTPUT_LOW_PRESET:  cfg_next.output_low_preset  = cfg_data;
                CFG_OUTPUT_HIGH_PRESET: cfg_next.output_high_preset = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direct_action      <= 1'b1;
            cfg_reg.sp_track           <= 1'b0;
            cfg_reg.deadband           <= '0;
            cfg_reg.hysteresis_band    <= '0;
            cfg_reg.sv_high_limit      <= Q_FULL;
            cfg_reg.sv_low_limit       <= Q_ZERO;
            cfg_reg.preset_output      <= Q_ZERO;
            cfg_reg.output_low_preset  <= Q_ZERO;
            cfg_reg.output_high_preset <= Q_FULL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/tpoc_core.sv =====
// ----------------------------------------------------------------------------
// tpoc_core
// Controller state and the one-pass step: mode, presets, setpoint, 3-level out.
// ----------------------------------------------------------------------------
`default_nettype none

module tpoc_core
    import tpoc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step_en,
    input  item_t     item,
    input  cfg_t      cfg,
    output result_t   result
);

    mode_t              mode_reg;
    mode_t              mode_next;
    logic signed [31:0] setpoint_reg;
    logic signed [31:0] setpoint_next;
    logic signed [31:0] output_reg;
    logic signed [31:0] output_next;
    logic signed [31:0] last_error_reg;
    logic signed [31:0] last_error_next;

    mode_t              mode_req;
    logic signed [31:0] sp_clamp;
    logic signed [32:0] diff;
    logic signed [31:0] err;
    logic signed [32:0] err_x;
    logic signed [32:0] db_x;
    logic signed [32:0] hy_x;
    logic signed [31:0] lvl_lo;
    logic signed [31:0] lvl_hi;
    logic signed [31:0] lvl;

    always_comb
    begin
        if (item.mode_request == REQ_KEEP)
            mode_req = mode_reg;
        else if (item.mode_request <= REQ_ROUT)
            mode_req = mode_t'(item.mode_request - 3'd1);
        else
            mode_req = MODE_OS;
    end

    // cascade clamp: low first, high wins on inverted limits
    always_comb
    begin
        sp_clamp = item.cascade_setpoint;
        if (sp_clamp < cfg.sv_low_limit)
            sp_clamp = cfg.sv_low_limit;
        if (sp_clamp > cfg.sv_high_limit)
            sp_clamp = cfg.sv_high_limit;
    end

    always_comb
    begin
        mode_next     = mode_req;
        setpoint_next = setpoint_reg;
        output_next   = output_reg;
        if (mode_req != MODE_OS)
        begin
            if (item.preset_switch != PSW_NONE)
            begin
                mode_next = MODE_MAN;
                case (item.preset_switch)
                    PSW_LOW:    output_next = cfg.output_low_preset;
                    PSW_HIGH:   output_next = cfg.output_high_preset;
                    PSW_PRESET: output_next = cfg.preset_output;
                    default:    output_next = output_reg;
                endcase
            end
            else if (item.manual_write && mode_req == MODE_MAN)
            begin
                output_next = item.manual_value;
            end
            if (mode_next == MODE_MAN && cfg.sp_track)
                setpoint_next = item.process_value;
            if (mode_next == MODE_RCAS)
                setpoint_next = item.remote_setpoint;
            if (mode_next == MODE_ROUT)
                output_next = item.remote_output;
            if (mode_next == MODE_CAS && item.cascade_connected)
                setpoint_next = sp_clamp;
        end
    end

    // saturated error against the updated setpoint
    always_comb
    begin
        diff = {item.process_value[31], item.process_value}
             - {setpoint_next[31], setpoint_next};
        if (diff[32] != diff[31])
            err = diff[32] ? S32_MIN : S32_MAX;
        else
            err = diff[31:0];
    end

    always_comb
    begin
        err_x = {err[31], err};
        db_x  = {2'b00, cfg.deadband};
        hy_x  = {2'b00, cfg.hysteresis_band};
        lvl_lo = cfg.direct_action ? Q_ZERO : Q_FULL;
        lvl_hi = cfg.direct_action ? Q_FULL : Q_ZERO;
        if (err >= last_error_reg)
        begin
            if (err_x < hy_x - db_x)
                lvl = lvl_lo;
            else if (err_x < db_x)
                lvl = Q_HALF;
            else
                lvl = lvl_hi;
        end
        else
        begin
            if (err_x > db_x - hy_x)
                lvl = lvl_hi;
            else if (err_x > -db_x)
                lvl = Q_HALF;
            else
                lvl = lvl_lo;
        end
    end

    logic               auto_mode;
    logic signed [31:0] output_fin;

    assign auto_mode = (mode_next != MODE_OS) && (mode_next != MODE_MAN)
                    && (mode_next != MODE_ROUT);
    assign output_fin      = auto_mode ? lvl : output_next;
    assign last_error_next = auto_mode ? err : last_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_AUT;
            setpoint_reg   <= '0;
            output_reg     <= '0;
            last_error_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            setpoint_reg   <= setpoint_next;
            output_reg     <= output_fin;
            last_error_reg <= last_error_next;
        end
    end

    always_comb
    begin
        result.open_pin       = output_fin > Q_HI_PIN;
        result.close_pin      = output_fin <= Q_LOW_PIN;
        result.output_value   = output_fin;
        result.setpoint_value = setpoint_next;
        result.current_mode   = mode_next;
        result.bad_flag       = mode_next == MODE_OS;
    end

endmodule

`default_nettype wire

// ===== rtl/three_position_onoff_controller_top.sv =====
// ----------------------------------------------------------------------------
// three_position_onoff_controller_top
// Three-position on/off controller with hysteresis, Q16.16 fixed point.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_stall    process sample and operator inputs
//   out       source     out_valid / out_stall  pins, output, setpoint, mode
//   cfg       sink       cfg_write_en           cfg_index, cfg_data
//
// Data path: input register, then the controller step into the result register.
// One transfer per cycle while out_stall stays low; state updates with the result.
// Reset loads the default configuration and AUT mode with zero state.
// out_stall holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module three_position_onoff_controller_top
    import tpoc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] process_value,
    input  wire logic        cascade_connected,
    input  wire logic [31:0] cascade_setpoint,
    input  wire logic [31:0] remote_setpoint,
    input  wire logic [31:0] remote_output,
    input  wire logic [1:0]  preset_switch,
    input  wire logic [2:0]  mode_request,
    input  wire logic        manual_write,
    input  wire logic [31:0] manual_value,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             open_pin,
    output logic             close_pin,
    output logic [31:0]      output_value,
    output logic [31:0]      setpoint_value,
    output logic [2:0]       current_mode,
    output logic             bad_flag,

    input  wire logic        cfg_write_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    logic    item_valid_next;
    result_t step_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    step_en;
    logic    in_xfer;

    tpoc_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    tpoc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign step_en  = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        if (in_xfer)
            item_valid_next = 1'b1;
        else if (step_en)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;

        if (step_en)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.process_value     <= process_value;
            item_reg.cascade_connected <= cascade_connected;
            item_reg.cascade_setpoint  <= cascade_setpoint;
            item_reg.remote_setpoint   <= remote_setpoint;
            item_reg.remote_output     <= remote_output;
            item_reg.preset_switch     <= preset_switch;
            item_reg.mode_request      <= mode_request;
            item_reg.manual_write      <= manual_write;
            item_reg.manual_value      <= manual_value;
        end
        if (step_en)
            result_reg <= step_result;
    end

    assign out_valid      = out_valid_reg;
    assign open_pin       = result_reg.open_pin;
    assign close_pin      = result_reg.close_pin;
    assign output_value   = result_reg.output_value;
    assign setpoint_value = result_reg.setpoint_value;
    assign current_mode   = result_reg.current_mode;
    assign bad_flag       = result_reg.bad_flag;

`ifndef NO_ASSERTIONS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> !in_stall)
        else $error("in_stall raised with empty input register");

    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(open_pin && close_pin))
        else $error("open and close pins both active");

    a_bad_tracks_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bad_flag == (current_mode == MODE_OS)))
        else $error("bad_flag disagrees with mode");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid)
        else $error("step did not produce a result");
`endif

endmodule

`default_nettype wire

// ===== test/tb_three_position_onoff_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_three_position_onoff_controller_top
// Self-checking bench for the three-position on/off controller. Items come
// from a queue through a bursty driver; a transfer-level controller predictor
// runs on each accepted input transfer. Each output transfer is checked field
// by field against the oldest prediction. The settings change between
// phases, only while the block is drained.
// ----------------------------------------------------------------------------
module tb_three_position_onoff_controller_top;
    import tpoc_pkg::*;

    localparam logic [2:0] REQ_OS    = 3'd1;
    localparam logic [2:0] REQ_MAN   = 3'd2;
    localparam logic [2:0] REQ_AUT   = 3'd3;
    localparam logic [2:0] REQ_CAS   = 3'd4;
    localparam logic [2:0] REQ_RCAS  = 3'd5;
    localparam logic [2:0] REQ_UNDEF = 3'd7;

    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_PER_PHASE = 228;
    localparam int LAST_PHASE    = 8;

    typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    item_t       drv_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        open_pin;
    logic        close_pin;
    logic [31:0] output_value;
    logic [31:0] setpoint_value;
    logic [2:0]  current_mode;
    logic        bad_flag;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // controller shadow: settings and state
    cfg_t               ctl_cfg;
    mode_t              ctl_mode;
    logic signed [31:0] ctl_setpoint;
    logic signed [31:0] ctl_output;
    logic signed [31:0] ctl_last_error;

    item_t     pending_items[$];
    result_t   expected_results[$];
    logic      in_accepted = 1'b0;
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        gap_left = 0;
    int        burst_left = 1;
    int        rx_cycle = 0;
    int        hold_left = 0;
    rx_style_t stall_style = RX_FREE;
    int        phase_center = 0;
    int        walk_pv = 0;

    three_position_onoff_controller_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .process_value     (drv_item.process_value),
        .cascade_connected (drv_item.cascade_connected),
        .cascade_setpoint  (drv_item.cascade_setpoint),
        .remote_setpoint   (drv_item.remote_setpoint),
        .remote_output     (drv_item.remote_output),
        .preset_switch     (drv_item.preset_switch),
        .mode_request      (drv_item.mode_request),
        .manual_write      (drv_item.manual_write),
        .manual_value      (drv_item.manual_value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .open_pin          (open_pin),
        .close_pin         (close_pin),
        .output_value      (output_value),
        .setpoint_value    (setpoint_value),
        .current_mode      (current_mode),
        .bad_flag          (bad_flag),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] three_level_output(input logic signed [31:0] err);
        longint             e;
        longint             db;
        longint             hy;
        logic signed [31:0] lvl_lo;
        logic signed [31:0] lvl_hi;
        logic signed [31:0] lvl;
        e = err;
        db = longint'({1'b0, ctl_cfg.deadband});
        hy = longint'({1'b0, ctl_cfg.hysteresis_band});
        lvl_lo = ctl_cfg.direct_action ? Q_ZERO : Q_FULL;
        lvl_hi = ctl_cfg.direct_action ? Q_FULL : Q_ZERO;
        // thresholds move with the trend of the error
        if (err >= ctl_last_error)
        begin
            if (e < hy - db)
                lvl = lvl_lo;
            else if (e < db)
                lvl = Q_HALF;
            else
                lvl = lvl_hi;
        end
        else
        begin
            if (e > db - hy)
                lvl = lvl_hi;
            else if (e > -db)
                lvl = Q_HALF;
            else
                lvl = lvl_lo;
        end
        return lvl;
    endfunction

    task automatic step_controller(input item_t it, output result_t r);
        logic signed [31:0] sp_clamped;
        logic signed [31:0] err;
        longint             diff;
        if (it.mode_request != REQ_KEEP)
            ctl_mode = (it.mode_request == REQ_UNDEF) ? MODE_OS
                                                      : mode_t'(it.mode_request - 3'd1);
        if (ctl_mode != MODE_OS)
        begin
            if (it.preset_switch != PSW_NONE)
            begin
                ctl_mode = MODE_MAN;
                case (it.preset_switch)
                    PSW_LOW:  ctl_output = ctl_cfg.output_low_preset;
                    PSW_HIGH: ctl_output = ctl_cfg.output_high_preset;
                    default:  ctl_output = ctl_cfg.preset_output;
                endcase
            end
            else if (it.manual_write && ctl_mode == MODE_MAN)
                ctl_output = it.manual_value;
            if (ctl_mode == MODE_MAN && ctl_cfg.sp_track)
                ctl_setpoint = it.process_value;
            if (ctl_mode == MODE_RCAS)
                ctl_setpoint = it.remote_setpoint;
            if (ctl_mode == MODE_ROUT)
                ctl_output = it.remote_output;
            if (ctl_mode == MODE_CAS && it.cascade_connected)
            begin
                // low limit first, so the high limit wins when inverted
                sp_clamped = it.cascade_setpoint;
                if (sp_clamped < ctl_cfg.sv_low_limit)
                    sp_clamped = ctl_cfg.sv_low_limit;
                if (sp_clamped > ctl_cfg.sv_high_limit)
                    sp_clamped = ctl_cfg.sv_high_limit;
                ctl_setpoint = sp_clamped;
            end
            if (ctl_mode != MODE_MAN && ctl_mode != MODE_ROUT)
            begin
                diff = longint'(it.process_value) - longint'(ctl_setpoint);
                if (diff > longint'(S32_MAX))
                    err = S32_MAX;
                else if (diff < longint'(S32_MIN))
                    err = S32_MIN;
                else
                    err = diff[31:0];
                ctl_output = three_level_output(err);
                ctl_last_error = err;
            end
        end
        r.open_pin       = ctl_output > Q_HI_PIN;
        r.close_pin      = ctl_output <= Q_LOW_PIN;
        r.output_value   = ctl_output;
        r.setpoint_value = ctl_setpoint;
        r.current_mode   = ctl_mode;
        r.bad_flag       = (ctl_mode == MODE_OS);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // driver: holds a stalled transfer, otherwise bursts and gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                drv_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        gap_left = 0;
                        burst_left = $urandom_range(20, 60);
                    end
                    else
                    begin
                        gap_left = $urandom_range(1, 5);
                        burst_left = $urandom_range(1, 8);
                    end
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with a long hold-off now and then
    always @(negedge clk)
    begin
        logic stall_now;
        rx_cycle++;
        if (rx_cycle % 113 == 0)
            stall_style = rx_style_t'($urandom_range(0, 3));
        if (hold_left > 0)
        begin
            hold_left--;
            stall_now = 1'b1;
        end
        else if (rx_cycle % 2500 == 600)
        begin
            hold_left = $urandom_range(200, 300);
            stall_now = 1'b1;
        end
        else
        begin
            case (stall_style)
                RX_FREE:  stall_now = 1'b0;
                RX_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
                RX_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
                default:  stall_now = (rx_cycle % 7) < 3;
            endcase
        end
        out_stall <= stall_now;
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        result_t want;
        in_accepted <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            step_controller(drv_item, want);
            expected_results.push_back(want);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("output transfer with no prediction pending");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("open_pin", 32'(want.open_pin), 32'(open_pin));
                check_field("close_pin", 32'(want.close_pin), 32'(close_pin));
                check_field("output_value", want.output_value, output_value);
                check_field("setpoint_value", want.setpoint_value, setpoint_value);
                check_field("current_mode", 32'(want.current_mode), 32'(current_mode));
                check_field("bad_flag", 32'(want.bad_flag), 32'(bad_flag));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int near_center(input int unsigned spread);
        return phase_center + int'($urandom_range(0, 2 * spread)) - int'(spread);
    endfunction

    function automatic logic [31:0] output_level();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return $urandom;
        if (pick < 45)
        begin
            case (pick % 4)
                0:       return Q_LOW_PIN;
                1:       return Q_LOW_PIN + 1;
                2:       return Q_HI_PIN;
                default: return Q_HI_PIN + 1;
            endcase
        end
        return $urandom_range(0, Q_FULL);
    endfunction

    task automatic make_random_item(output item_t it);
        int unsigned pick;
        it = '0;
        walk_pv += int'($urandom_range(0, 262144)) - 131072;
        if (walk_pv > phase_center + 1310720 || walk_pv < phase_center - 1310720)
            walk_pv = phase_center;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            it.process_value = $urandom;
        else if (pick < 11)
            it.process_value = pick[0] ? S32_MAX : S32_MIN;
        else
            it.process_value = walk_pv;
        it.cascade_connected = ($urandom_range(0, 9) != 0);
        it.cascade_setpoint = ($urandom_range(0, 9) == 0) ? $urandom : near_center(655360);
        it.remote_setpoint = ($urandom_range(0, 9) == 0) ? $urandom : near_center(655360);
        it.remote_output = output_level();
        it.manual_value = output_level();
        it.manual_write = 1'($urandom_range(0, 1));
        it.preset_switch = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(PSW_LOW, PSW_PRESET))
                                                        : PSW_NONE;
        if ($urandom_range(0, 99) < 85)
            it.mode_request = REQ_KEEP;
        else if ($urandom_range(0, 9) < 6)
            it.mode_request = 3'($urandom_range(REQ_AUT, REQ_RCAS));
        else
            it.mode_request = 3'($urandom_range(REQ_OS, REQ_UNDEF));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_CONTROL_FLAGS:
            begin
                ctl_cfg.direct_action = data[0];
                ctl_cfg.sp_track = data[1];
            end
            CFG_DEADBAND:           ctl_cfg.deadband = data[30:0];
            CFG_HYSTERESIS_BAND:    ctl_cfg.hysteresis_band = data[30:0];
            CFG_SV_HIGH_LIMIT:      ctl_cfg.sv_high_limit = data;
            CFG_SV_LOW_LIMIT:       ctl_cfg.sv_low_limit = data;
            CFG_PRESET_OUTPUT:      ctl_cfg.preset_output = data;
            CFG_OUTPUT_LOW_PRESET:  ctl_cfg.output_low_preset = data;
            default:                ctl_cfg.output_high_preset = data;
        endcase
    endtask

    task automatic configure_phase(input int p);
        logic [31:0] flags;
        logic [31:0] db;
        logic [31:0] hy;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] pre;
        logic [31:0] lowp;
        logic [31:0] highp;
        flags = $urandom_range(0, 3);
        db = $urandom_range(0, 655360);
        hy = $urandom_range(0, 655360);
        phase_center = $urandom_range(0, Q_FULL);
        walk_pv = phase_center;
        lo = phase_center - int'($urandom_range(0, 1966080));
        hi = phase_center + int'($urandom_range(0, 1966080));
        pre = output_level();
        lowp = output_level();
        highp = output_level();
        case (p)
            1:
            begin
                flags = 1;
                db = 327680;
                hy = 131072;
            end
            2:
            begin
                flags = 0;
                db = 0;
                hy = 0;
                hi = S32_MAX;
                lo = S32_MIN;
                pre = S32_MIN;
                lowp = S32_MAX;
                highp = S32_MIN;
            end
            3:
            begin
                flags = 3;
                db = 32'h7FFF_FFFF;
                hy = 32'h7FFF_FFFF;
            end
            4:
            begin
                // hysteresis wider than deadband, inverted limits
                flags = 2;
                db = 655360;
                hy = 983040;
                {hi, lo} = {lo, hi};
            end
            5:
            begin
                flags = 1;
                db = 0;
                hy = 32'h7FFF_FFFF;
            end
            6:
            begin
                db = 32'h7FFF_FFFF;
                hy = 0;
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    {hi, lo} = {lo, hi};
            end
        endcase
        write_reg(CFG_CONTROL_FLAGS, flags);
        write_reg(CFG_DEADBAND, db);
        write_reg(CFG_HYSTERESIS_BAND, hy);
        write_reg(CFG_SV_HIGH_LIMIT, hi);
        write_reg(CFG_SV_LOW_LIMIT, lo);
        write_reg(CFG_PRESET_OUTPUT, pre);
        write_reg(CFG_OUTPUT_LOW_PRESET, lowp);
        write_reg(CFG_OUTPUT_HIGH_PRESET, highp);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        item_t it;
        ctl_cfg.direct_action = 1'b1;
        ctl_cfg.sp_track = 1'b0;
        ctl_cfg.deadband = '0;
        ctl_cfg.hysteresis_band = '0;
        ctl_cfg.sv_high_limit = Q_FULL;
        ctl_cfg.sv_low_limit = Q_ZERO;
        ctl_cfg.preset_output = Q_ZERO;
        ctl_cfg.output_low_preset = Q_ZERO;
        ctl_cfg.output_high_preset = Q_FULL;
        ctl_mode = MODE_AUT;
        ctl_setpoint = '0;
        ctl_output = '0;
        ctl_last_error = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed items on the reset settings
        it = '0;
        pending_items.push_back(it);
        it.process_value = S32_MAX;
        pending_items.push_back(it);
        it.process_value = S32_MIN;
        pending_items.push_back(it);
        // error saturation both ways
        it = '0;
        it.mode_request = REQ_RCAS;
        it.remote_setpoint = S32_MIN;
        it.process_value = S32_MAX;
        pending_items.push_back(it);
        it.remote_setpoint = S32_MAX;
        it.process_value = S32_MIN;
        pending_items.push_back(it);
        // cascade unwired, then clamped low and high
        it = '0;
        it.mode_request = REQ_CAS;
        it.cascade_setpoint = Q_HALF;
        it.process_value = Q_HALF;
        pending_items.push_back(it);
        it.mode_request = REQ_KEEP;
        it.cascade_connected = 1'b1;
        it.cascade_setpoint = S32_MIN;
        pending_items.push_back(it);
        it.cascade_setpoint = S32_MAX;
        pending_items.push_back(it);
        it.cascade_setpoint = Q_HALF;
        it.process_value = Q_HALF + 1;
        pending_items.push_back(it);
        // manual writes, then presets that override a write
        it = '0;
        it.mode_request = REQ_MAN;
        it.manual_write = 1'b1;
        it.manual_value = S32_MAX;
        pending_items.push_back(it);
        it.mode_request = REQ_KEEP;
        it.manual_value = S32_MIN;
        pending_items.push_back(it);
        it.preset_switch = PSW_LOW;
        pending_items.push_back(it);
        it.preset_switch = PSW_HIGH;
        pending_items.push_back(it);
        it.preset_switch = PSW_PRESET;
        pending_items.push_back(it);
        // manual write outside manual mode
        it = '0;
        it.mode_request = REQ_AUT;
        it.manual_write = 1'b1;
        it.manual_value = Q_FULL;
        it.process_value = Q_FULL;
        pending_items.push_back(it);
        // pin thresholds through remote output
        it = '0;
        it.mode_request = REQ_ROUT;
        it.remote_output = Q_LOW_PIN;
        pending_items.push_back(it);
        it.mode_request = REQ_KEEP;
        it.remote_output = Q_LOW_PIN + 1;
        pending_items.push_back(it);
        it.remote_output = Q_HI_PIN;
        pending_items.push_back(it);
        it.remote_output = Q_HI_PIN + 1;
        pending_items.push_back(it);
        // out of service freezes state
        it = '0;
        it.mode_request = REQ_OS;
        it.preset_switch = PSW_HIGH;
        it.manual_write = 1'b1;
        it.manual_value = Q_FULL;
        it.process_value = S32_MAX;
        pending_items.push_back(it);
        it = '0;
        it.mode_request = REQ_UNDEF;
        it.preset_switch = PSW_LOW;
        pending_items.push_back(it);
        // rising then falling error in auto
        it = '0;
        it.mode_request = REQ_AUT;
        it.process_value = -Q_HALF;
        pending_items.push_back(it);
        it.mode_request = REQ_KEEP;
        it.process_value = Q_HALF;
        pending_items.push_back(it);
        it.process_value = Q_ZERO;
        pending_items.push_back(it);
        wait_drained();

        for (int p = 1; p <= LAST_PHASE; p++)
        begin
            configure_phase(p);
            it = '0;
            it.mode_request = REQ_CAS;
            it.cascade_connected = 1'b1;
            it.cascade_setpoint = S32_MIN;
            it.process_value = phase_center;
            pending_items.push_back(it);
            it.cascade_setpoint = S32_MAX;
            pending_items.push_back(it);
            repeat (RANDOM_PER_PHASE)
            begin
                make_random_item(it);
                pending_items.push_back(it);
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
